>>> design/stuffed_trainer_frame_decoder_core_defines.svh
// Assertion macros shared by the checker.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef STUFFED_TRAINER_FRAME_DECODER_CORE_DEFINES_SVH
`define STUFFED_TRAINER_FRAME_DECODER_CORE_DEFINES_SVH

// Same-cycle implication
`define STFD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define STFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/stfd_pkg.sv
package stfd_pkg;

  // Default build
  localparam int DEF_CHANNELS     = 8;
  localparam int DEF_BUFFER_LIMIT = 32;

  // Fixed field widths
  localparam int BYTE_W       = 8;
  localparam int CHAN_W       = 12;
  localparam int COUNT_OUT_W  = 6;
  localparam int OUT_CHANNELS = 8;

  // Deframer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_XOR   = 4'b0100,
    ST_FRAME = 4'b1000
  } parse_state_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_NONE       = 2'd0,
    STATUS_GOOD       = 2'd1,
    STATUS_CSUM_ERR   = 2'd2,
    STATUS_OTHER_TYPE = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DELIMITER    = 2'd0,
    CFG_ESCAPE       = 2'd1,
    CFG_UNMASK       = 2'd2,
    CFG_TRAINER_TYPE = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [BYTE_W-1:0] delimiter;
    logic [BYTE_W-1:0] escape;
    logic [BYTE_W-1:0] unmask;
    logic [BYTE_W-1:0] trainer_type;
  } cfg_t;

  typedef struct packed {
    logic    fire;
    status_e status;
  } check_t;

endpackage

>>> design/stfd_deframer.sv
module stfd_deframer #(
  parameter int  CHANNELS     = stfd_pkg::DEF_CHANNELS,
  parameter int  BUFFER_LIMIT = stfd_pkg::DEF_BUFFER_LIMIT,
  localparam int PAIRS        = (CHANNELS + 1) / 2,
  localparam int FRAME_LEN    = 3 * PAIRS + 2,
  localparam int CNT_W        = $clog2(BUFFER_LIMIT + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic [stfd_pkg::BYTE_W-1:0]           byte_i,
  input  stfd_pkg::cfg_t                        cfg_i,
  input  logic                                  check_fire_i,
  output logic [CNT_W-1:0]                      count_o,
  output logic [stfd_pkg::BYTE_W-1:0]           store_o [FRAME_LEN]
);
  import stfd_pkg::*;

  parse_state_e      state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0] store_q [FRAME_LEN];
  logic [BYTE_W-1:0] store_d [FRAME_LEN];
  logic              store_req;
  logic              clear;
  logic              wr_en;
  logic [BYTE_W-1:0] store_val;

  // Unstuffing state machine
  always_comb begin
    state_d   = state_q;
    store_req = 1'b0;
    clear     = 1'b0;
    store_val = byte_i;
    case (state_q)
      ST_START: begin
        if (byte_i == cfg_i.delimiter) begin
          state_d = ST_FRAME;
          clear   = 1'b1;
        end else begin
          store_req = 1'b1;
        end
      end
      ST_FRAME: begin
        if (byte_i == cfg_i.escape) begin
          state_d = ST_XOR;
        end else if (byte_i == cfg_i.delimiter) begin
          clear = 1'b1;
        end else begin
          store_req = 1'b1;
        end
      end
      ST_XOR: begin
        // unmask cases take priority over a bare delimiter
        if (byte_i == (cfg_i.escape ^ cfg_i.unmask) ||
            byte_i == (cfg_i.delimiter ^ cfg_i.unmask)) begin
          store_req = 1'b1;
          store_val = byte_i ^ cfg_i.unmask;
          state_d   = ST_FRAME;
        end else if (byte_i == cfg_i.delimiter) begin
          clear   = 1'b1;
          state_d = ST_FRAME;
        end else begin
          state_d = ST_START;
        end
      end
      default: begin
        if (byte_i == cfg_i.delimiter) begin
          clear   = 1'b1;
          state_d = ST_START;
        end else begin
          store_req = 1'b1;
        end
      end
    endcase
  end

  // Count: a byte at the limit is dropped and clears the count
  always_comb begin
    count_d = count_q;
    if (clear) begin
      count_d = '0;
    end else if (store_req) begin
      if (count_q < CNT_W'(BUFFER_LIMIT)) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        count_d = '0;
      end
    end
  end

  // Only the first FRAME_LEN positions are ever read back
  assign wr_en = store_req && !clear && (count_q < CNT_W'(BUFFER_LIMIT)) &&
                 (count_q < CNT_W'(FRAME_LEN));

  always_comb begin
    for (int e = 0; e < FRAME_LEN; e++) begin
      store_d[e] = (wr_en && count_q == CNT_W'(e)) ? store_val : store_q[e];
    end
  end

  assign count_o = count_d;
  assign store_o = store_d;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else if (accept_i) begin
      state_q <= check_fire_i ? ST_IDLE : state_d;
      count_q <= count_d;
    end
  end

  // Frame store
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      store_q <= store_d;
    end
  end

endmodule

>>> design/stfd_frame_check.sv
module stfd_frame_check #(
  parameter int  CHANNELS     = stfd_pkg::DEF_CHANNELS,
  parameter int  BUFFER_LIMIT = stfd_pkg::DEF_BUFFER_LIMIT,
  localparam int PAIRS        = (CHANNELS + 1) / 2,
  localparam int FRAME_LEN    = 3 * PAIRS + 2,
  localparam int CNT_W        = $clog2(BUFFER_LIMIT + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic [CNT_W-1:0]                      count_i,
  input  logic [stfd_pkg::BYTE_W-1:0]           store_i [FRAME_LEN],
  input  logic [stfd_pkg::BYTE_W-1:0]           trainer_type_i,
  output stfd_pkg::check_t                      check_o,
  output logic [stfd_pkg::CHAN_W-1:0]           chan_o [stfd_pkg::OUT_CHANNELS]
);
  import stfd_pkg::*;

  localparam int NUM_CHAN = 2 * PAIRS;

  logic [BYTE_W-1:0] csum;
  logic              csum_ok;
  logic              update;
  logic [CHAN_W-1:0] unpacked [NUM_CHAN];
  logic [CHAN_W-1:0] chan_q   [NUM_CHAN];
  logic [CHAN_W-1:0] chan_d   [NUM_CHAN];

  // XOR over all bytes but the last
  always_comb begin
    csum = '0;
    for (int k = 0; k < FRAME_LEN - 1; k++) begin
      csum = csum ^ store_i[k];
    end
  end

  assign csum_ok = (csum == store_i[FRAME_LEN-1]);

  // Check runs whenever a full frame is held
  always_comb begin
    check_o.fire   = (count_i >= CNT_W'(FRAME_LEN));
    check_o.status = STATUS_NONE;
    if (check_o.fire) begin
      if (!csum_ok) begin
        check_o.status = STATUS_CSUM_ERR;
      end else if (store_i[0] == trainer_type_i) begin
        check_o.status = STATUS_GOOD;
      end else begin
        check_o.status = STATUS_OTHER_TYPE;
      end
    end
  end

  assign update = (check_o.status == STATUS_GOOD);

  // Three bytes carry two channels: lo byte + high nibble, then mixed nibbles
  always_comb begin
    for (int p = 0; p < PAIRS; p++) begin
      unpacked[2*p]   = {store_i[3*p+2][7:4], store_i[3*p+1]};
      unpacked[2*p+1] = {store_i[3*p+3][3:0], store_i[3*p+2][3:0], store_i[3*p+3][7:4]};
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      chan_d[k] = update ? unpacked[k] : chan_q[k];
    end
  end

  // Held channel values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        chan_q[k] <= '0;
      end
    end else if (accept_i && update) begin
      chan_q <= unpacked;
    end
  end

  // Channels beyond the build's count read as zero
  for (genvar g = 0; g < OUT_CHANNELS; g++) begin : g_chan_out
    if (g < CHANNELS) begin : g_used
      assign chan_o[g] = chan_d[g];
    end else begin : g_unused
      assign chan_o[g] = '0;
    end
  end

endmodule

>>> design/stuffed_trainer_frame_decoder_core.sv
// Byte-stuffed trainer frame decoder.
// The result of each accepted byte is registered in the output register.
// Throughput: one byte per cycle while in_stall_o is low; the unstuffing state,
// count and store update in the same cycle: the state loop is one register stage.
// Reset (rst_ni, async, active low): idle state, count and channels zero, config
// registers to their default bytes; frame store contents undefined until written.
module stuffed_trainer_frame_decoder_core #(
  parameter int CHANNELS     = stfd_pkg::DEF_CHANNELS,
  parameter int BUFFER_LIMIT = stfd_pkg::DEF_BUFFER_LIMIT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // byte input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [stfd_pkg::BYTE_W-1:0]          rx_byte_i,
  // result output
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           status_o,
  output logic [stfd_pkg::COUNT_OUT_W-1:0]     stored_count_o,
  output logic [stfd_pkg::CHAN_W-1:0]          chan_0_o,
  output logic [stfd_pkg::CHAN_W-1:0]          chan_1_o,
  output logic [stfd_pkg::CHAN_W-1:0]          chan_2_o,
  output logic [stfd_pkg::CHAN_W-1:0]          chan_3_o,
  output logic [stfd_pkg::CHAN_W-1:0]          chan_4_o,
  output logic [stfd_pkg::CHAN_W-1:0]          chan_5_o,
  output logic [stfd_pkg::CHAN_W-1:0]          chan_6_o,
  output logic [stfd_pkg::CHAN_W-1:0]          chan_7_o,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [1:0]                           cfg_index_i,
  input  logic [stfd_pkg::BYTE_W-1:0]          cfg_data_i
);
  import stfd_pkg::*;

  localparam int PAIRS     = (CHANNELS + 1) / 2;
  localparam int FRAME_LEN = 3 * PAIRS + 2;
  localparam int CNT_W     = $clog2(BUFFER_LIMIT + 1);

  cfg_t              cfg_q;
  logic              accept;
  logic [CNT_W-1:0]  count_d;
  logic [BYTE_W-1:0] store_d [FRAME_LEN];
  check_t            check;
  logic [CHAN_W-1:0] chan_d [OUT_CHANNELS];

  logic                   out_valid_q;
  status_e                status_q;
  logic [COUNT_OUT_W-1:0] count_q;
  logic [CHAN_W-1:0]      chan_q [OUT_CHANNELS];

  // Handshake: take a byte unless the result register is full and stalled
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter    <= 8'd126;
      cfg_q.escape       <= 8'd125;
      cfg_q.unmask       <= 8'd32;
      cfg_q.trainer_type <= 8'd128;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DELIMITER:    cfg_q.delimiter    <= cfg_data_i;
        CFG_ESCAPE:       cfg_q.escape       <= cfg_data_i;
        CFG_UNMASK:       cfg_q.unmask       <= cfg_data_i;
        CFG_TRAINER_TYPE: cfg_q.trainer_type <= cfg_data_i;
        default: ;
      endcase
    end
  end

  stfd_deframer #(
    .CHANNELS    (CHANNELS),
    .BUFFER_LIMIT(BUFFER_LIMIT)
  ) u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (rx_byte_i),
    .cfg_i       (cfg_q),
    .check_fire_i(check.fire),
    .count_o     (count_d),
    .store_o     (store_d)
  );

  stfd_frame_check #(
    .CHANNELS    (CHANNELS),
    .BUFFER_LIMIT(BUFFER_LIMIT)
  ) u_frame_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .count_i       (count_d),
    .store_i       (store_d),
    .trainer_type_i(cfg_q.trainer_type),
    .check_o       (check),
    .chan_o        (chan_d)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= check.status;
      count_q  <= COUNT_OUT_W'(count_d);
      chan_q   <= chan_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign stored_count_o = count_q;
  assign chan_0_o       = chan_q[0];
  assign chan_1_o       = chan_q[1];
  assign chan_2_o       = chan_q[2];
  assign chan_3_o       = chan_q[3];
  assign chan_4_o       = chan_q[4];
  assign chan_5_o       = chan_q[5];
  assign chan_6_o       = chan_q[6];
  assign chan_7_o       = chan_q[7];

endmodule

>>> design/stfd_checker.sv
`include "stuffed_trainer_frame_decoder_core_defines.svh"

module stfd_checker #(
  parameter int CHANNELS     = stfd_pkg::DEF_CHANNELS,
  parameter int BUFFER_LIMIT = stfd_pkg::DEF_BUFFER_LIMIT
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [1:0]                           status_o,
  input logic [stfd_pkg::COUNT_OUT_W-1:0]     stored_count_o,
  input logic [stfd_pkg::CHAN_W-1:0]          chan_0_o,
  input logic [stfd_pkg::CHAN_W-1:0]          chan_1_o,
  input logic [stfd_pkg::CHAN_W-1:0]          chan_2_o,
  input logic [stfd_pkg::CHAN_W-1:0]          chan_3_o,
  input logic [stfd_pkg::CHAN_W-1:0]          chan_4_o,
  input logic [stfd_pkg::CHAN_W-1:0]          chan_5_o,
  input logic [stfd_pkg::CHAN_W-1:0]          chan_6_o,
  input logic [stfd_pkg::CHAN_W-1:0]          chan_7_o
);
  import stfd_pkg::*;

  localparam int PAIRS     = (CHANNELS + 1) / 2;
  localparam int FRAME_LEN = 3 * PAIRS + 2;
  localparam int RES_W     = 2 + COUNT_OUT_W + OUT_CHANNELS * CHAN_W;

  localparam logic [COUNT_OUT_W-1:0] FRAME_CNT = COUNT_OUT_W'(FRAME_LEN);

  logic             in_accept;
  logic             out_held;
  logic             checked;
  logic [RES_W-1:0] result_bits;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_held    = out_valid_o && out_stall_i;
  assign checked     = (BUFFER_LIMIT < 64) && out_valid_o && (status_o != STATUS_NONE);
  assign result_bits = {status_o, stored_count_o, chan_7_o, chan_6_o, chan_5_o, chan_4_o,
                        chan_3_o, chan_2_o, chan_1_o, chan_0_o};

  // every accepted byte yields a result next cycle
  `STFD_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid_o, "no result after accept")

  // input is only held off by a full, stalled result register
  `STFD_ASSERT_IMPLIES(a_stall_when_full, in_stall_o, out_held, "stall with no result")

  // a frame check needs a whole frame in the store
  `STFD_ASSERT_IMPLIES(a_check_needs_frame, checked, stored_count_o >= FRAME_CNT, "short check")

  // stalled result holds
  `STFD_ASSERT_NEXT(a_result_held, out_held, out_valid_o && $stable(result_bits), "result moved")

endmodule

bind stuffed_trainer_frame_decoder_core stfd_checker #(
  .CHANNELS    (CHANNELS),
  .BUFFER_LIMIT(BUFFER_LIMIT)
) u_stfd_checker (.*);

>>> tb/tb_stuffed_trainer_frame_decoder_core.sv
`timescale 1ns / 1ps

import stfd_pkg::*;

localparam int PAIRS       = (DEF_CHANNELS + 1) / 2;
localparam int FRAME_BYTES = 3 * PAIRS + 2;

// One result transaction as the decoder should present it
typedef struct packed {
  status_e                             status;
  logic [COUNT_OUT_W-1:0]              count;
  logic [OUT_CHANNELS-1:0][CHAN_W-1:0] chans;
} decode_result_t;

// Tracks the deframer, the payload store and the held channels, and
// queues the result each accepted byte should produce
class trainer_decode_tracker;
  logic [BYTE_W-1:0] delim, esc, mask, trainer_id;
  parse_state_e      deframe_state;
  int unsigned       held;
  logic [BYTE_W-1:0] payload [FRAME_BYTES];
  logic [CHAN_W-1:0] chans [OUT_CHANNELS];
  decode_result_t    awaited_results [$];
  int unsigned       errors, results, good_frames, csum_errors, foreign_frames, wraps;

  function new();
    delim         = 8'd126;
    esc           = 8'd125;
    mask          = 8'd32;
    trainer_id    = 8'd128;
    deframe_state = ST_IDLE;
    held          = 0;
    foreach (payload[k]) payload[k] = '0;
    foreach (chans[k]) chans[k] = '0;
    errors         = 0;
    results        = 0;
    good_frames    = 0;
    csum_errors    = 0;
    foreign_frames = 0;
    wraps          = 0;
  endfunction

  function void write_reg(cfg_index_e idx, logic [BYTE_W-1:0] v);
    case (idx)
      CFG_DELIMITER: delim = v;
      CFG_ESCAPE:    esc = v;
      CFG_UNMASK:    mask = v;
      default:       trainer_id = v;
    endcase
  endfunction

  // Full store: byte dropped and count cleared
  function void keep_byte(logic [BYTE_W-1:0] b);
    if (held < DEF_BUFFER_LIMIT) begin
      if (held < FRAME_BYTES) payload[held] = b;
      held++;
    end else begin
      held = 0;
      wraps++;
    end
  endfunction

  // Three bytes carry two 12-bit channels
  function void unpack_channels();
    logic [BYTE_W-1:0] a, b, c;
    for (int p = 0; p < PAIRS; p++) begin
      a = payload[1 + 3 * p];
      b = payload[2 + 3 * p];
      c = payload[3 + 3 * p];
      chans[2 * p]     = {b[7:4], a};
      chans[2 * p + 1] = {c[3:0], b[3:0], c[7:4]};
    end
  endfunction

  function void absorb_byte(logic [BYTE_W-1:0] d);
    logic [BYTE_W-1:0] sum;
    decode_result_t    r;
    r.status = STATUS_NONE;
    case (deframe_state)
      ST_START: begin
        if (d == delim) begin
          deframe_state = ST_FRAME;
          held = 0;
        end else keep_byte(d);
      end
      // escape test takes priority when escape and delimiter coincide
      ST_FRAME: begin
        if (d == esc) deframe_state = ST_XOR;
        else if (d == delim) held = 0;
        else keep_byte(d);
      end
      // unmask cases win over a plain delimiter
      ST_XOR: begin
        if (d == (esc ^ mask) || d == (delim ^ mask)) begin
          keep_byte(d ^ mask);
          deframe_state = ST_FRAME;
        end else if (d == delim) begin
          held = 0;
          deframe_state = ST_FRAME;
        end else deframe_state = ST_START;
      end
      default: begin
        if (d == delim) begin
          held = 0;
          deframe_state = ST_START;
        end else keep_byte(d);
      end
    endcase

    // checksum then type, re-run after every byte while a frame is held
    if (held >= FRAME_BYTES) begin
      sum = '0;
      for (int k = 0; k < FRAME_BYTES - 1; k++) sum ^= payload[k];
      if (sum != payload[FRAME_BYTES-1]) begin
        r.status = STATUS_CSUM_ERR;
        csum_errors++;
      end else if (payload[0] == trainer_id) begin
        unpack_channels();
        r.status = STATUS_GOOD;
        good_frames++;
      end else begin
        r.status = STATUS_OTHER_TYPE;
        foreign_frames++;
      end
      deframe_state = ST_IDLE;
    end

    r.count = COUNT_OUT_W'(held);
    for (int k = 0; k < OUT_CHANNELS; k++) r.chans[k] = (k < DEF_CHANNELS) ? chans[k] : '0;
    awaited_results.push_back(r);
  endfunction

  function void match_result(logic [1:0] st, logic [COUNT_OUT_W-1:0] cnt,
                             logic [OUT_CHANNELS-1:0][CHAN_W-1:0] ch);
    decode_result_t e;
    if (awaited_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, status %0d count %0d", $time, st, cnt);
      return;
    end
    e = awaited_results.pop_front();
    results++;
    if (st !== e.status) begin
      errors++;
      $display("%0t: status expected %0d actual %0d", $time, e.status, st);
    end
    if (cnt !== e.count) begin
      errors++;
      $display("%0t: stored_count expected %0d actual %0d", $time, e.count, cnt);
    end
    for (int k = 0; k < OUT_CHANNELS; k++) begin
      if (ch[k] !== e.chans[k]) begin
        errors++;
        $display("%0t: chan_%0d expected %0d actual %0d", $time, k, e.chans[k], ch[k]);
      end
    end
  endfunction
endclass

module tb_stuffed_trainer_frame_decoder_core;

  localparam int LATENCY     = 1;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 80;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [BYTE_W-1:0]      rx_byte_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [1:0]             status_o;
  logic [COUNT_OUT_W-1:0] stored_count_o;
  logic [CHAN_W-1:0]      chan_0_o, chan_1_o, chan_2_o, chan_3_o;
  logic [CHAN_W-1:0]      chan_4_o, chan_5_o, chan_6_o, chan_7_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_index_i;
  logic [BYTE_W-1:0]      cfg_data_i;

  trainer_decode_tracker tracker;
  logic [BYTE_W-1:0]     frame_buf [FRAME_BYTES];
  bit                    sender_calm, rx_calm, rx_hold_req;
  int unsigned           bytes_sent, cycles, settings_run;

  stuffed_trainer_frame_decoder_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run guard
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_stuffed_trainer_frame_decoder_core: done, errors");
    $finish;
  end

  // Result side: random stalls, calm stretches and one long hold-off
  initial begin : result_side
    int unsigned w;
    out_stall_i = 1'b0;
    rx_calm     = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      w = rx_calm ? 0 : $urandom_range(0, 17);
      if (w != 0) begin
        out_stall_i = 1'b1;
        repeat (w) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      tracker.match_result(status_o, stored_count_o,
                           {chan_7_o, chan_6_o, chan_5_o, chan_4_o,
                            chan_3_o, chan_2_o, chan_1_o, chan_0_o});
    end
  end

  // One byte transaction, preceded by a random gap
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.absorb_byte(b);
    bytes_sent++;
  endtask

  task automatic send_stuffed(input logic [BYTE_W-1:0] b);
    if (b == tracker.esc || b == tracker.delim) begin
      send_byte(tracker.esc);
      send_byte(b ^ tracker.mask);
    end else send_byte(b);
  endtask

  // Two delimiters reach the in-frame state from any state when escape and delimiter differ
  task automatic send_frame(input int unsigned len);
    send_byte(tracker.delim);
    send_byte(tracker.delim);
    for (int i = 0; i < len; i++) send_stuffed(frame_buf[i]);
  endtask

  // Payload bytes, leaning on the escape and delimiter values
  function automatic logic [BYTE_W-1:0] pick_byte();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return tracker.esc;
    if (sel == 1) return tracker.delim;
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [BYTE_W-1:0] non_delim_byte();
    logic [BYTE_W-1:0] v;
    v = BYTE_W'($urandom);
    if (v == tracker.delim) v = ~v;
    return v;
  endfunction

  function automatic void seal_frame(bit csum_ok);
    logic [BYTE_W-1:0] sum;
    sum = '0;
    for (int k = 0; k < FRAME_BYTES - 1; k++) sum ^= frame_buf[k];
    frame_buf[FRAME_BYTES-1] = csum_ok ? sum : sum ^ BYTE_W'(1 << $urandom_range(0, 7));
  endfunction

  function automatic void build_frame(bit type_ok, bit csum_ok);
    for (int i = 0; i < FRAME_BYTES; i++) frame_buf[i] = pick_byte();
    if (type_ok) frame_buf[0] = tracker.trainer_id;
    seal_frame(csum_ok);
  endfunction

  task automatic write_reg(input cfg_index_e idx, input logic [BYTE_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    tracker.write_reg(idx, v);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(input logic [BYTE_W-1:0] d, input logic [BYTE_W-1:0] e,
                           input logic [BYTE_W-1:0] m, input logic [BYTE_W-1:0] t);
    write_reg(CFG_DELIMITER, d);
    write_reg(CFG_ESCAPE, e);
    write_reg(CFG_UNMASK, m);
    write_reg(CFG_TRAINER_TYPE, t);
    settings_run++;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Mostly well-formed frames, plus truncation, noise, bad escapes and long runs
  task automatic run_phase(input int unsigned n);
    int unsigned goal, r;
    goal = bytes_sent + n;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 3) == 0) sender_calm = !sender_calm;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        build_frame($urandom_range(0, 6) != 0, $urandom_range(0, 6) != 0);
        send_frame(FRAME_BYTES);
      end else if (r < 78) begin
        build_frame(1'b1, 1'b1);
        send_frame($urandom_range(1, FRAME_BYTES - 2));
      end else if (r < 86) begin
        repeat ($urandom_range(1, 6)) send_byte(pick_byte());
      end else if (r < 92) begin
        send_byte(tracker.esc);
        send_byte(pick_byte());
      end else begin
        // runs of non-delimiter bytes longer than a frame
        repeat ($urandom_range(18, 24)) send_byte(non_delim_byte());
      end
    end
  endtask

  initial begin
    tracker      = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    rx_byte_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_DELIMITER;
    cfg_data_i   = '0;
    sender_calm  = 1'b0;
    rx_hold_req  = 1'b0;
    bytes_sent   = 0;
    settings_run = 1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: byte extremes, then a good frame with stuffed bytes
    send_byte(8'h00);
    send_byte(8'hFF);
    build_frame(1'b1, 1'b1);
    frame_buf[1] = 8'h00;
    frame_buf[2] = 8'hFF;
    frame_buf[3] = tracker.esc;
    frame_buf[4] = tracker.delim;
    seal_frame(1'b1);
    send_frame(FRAME_BYTES);

    run_phase(PHASE_BYTES);

    // Low extremes; escaped bytes here match both unmask and delimiter
    settle();
    configure(8'h00, 8'hFF, 8'hFF, 8'h00);
    sender_calm = 1'b1;
    rx_hold_req = 1'b1;
    run_phase(PHASE_BYTES);

    // High extremes, zero mask
    settle();
    configure(8'hFF, 8'h00, 8'h00, 8'hFF);
    run_phase(PHASE_BYTES);

    // Escape equal to delimiter
    settle();
    configure(8'h5A, 8'h5A, 8'h20, 8'h81);
    run_phase(PHASE_BYTES);

    settle();
    configure(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    run_phase(PHASE_BYTES);

    settle();
    if (tracker.awaited_results.size() != 0) begin
      tracker.errors += tracker.awaited_results.size();
      $display("%0t: %0d results never arrived", $time, tracker.awaited_results.size());
    end

    $display("covered %0d bytes under %0d register settings, %0d results checked",
             bytes_sent, settings_run, tracker.results);
    $display("frames: %0d good, %0d bad checksum, %0d other type; %0d store wraps",
             tracker.good_frames, tracker.csum_errors, tracker.foreign_frames,
             tracker.wraps);
    if (tracker.errors == 0) begin
      $display("tb_stuffed_trainer_frame_decoder_core: done, clean");
    end else begin
      $display("tb_stuffed_trainer_frame_decoder_core: done, errors");
    end
    $finish;
  end

endmodule
